// File: sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Codes, field widths and reset values that the sequencer uses.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int ACTION_W  = 2;
    localparam int PATTERN_W = 3;
    localparam int STEP_W    = 3;
    localparam int TICKS_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Actions carried by an input transaction.
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PLAY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP = 2'd2;

    // Pattern codes. Code seven is unused but is held like any other.
    localparam logic [PATTERN_W-1:0] PAT_OFF    = 3'd0;
    localparam logic [PATTERN_W-1:0] PAT_SHORT  = 3'd1;
    localparam logic [PATTERN_W-1:0] PAT_LONG   = 3'd2;
    localparam logic [PATTERN_W-1:0] PAT_DOUBLE = 3'd3;
    localparam logic [PATTERN_W-1:0] PAT_TRIPLE = 3'd4;
    localparam logic [PATTERN_W-1:0] PAT_CONT   = 3'd5;
    localparam logic [PATTERN_W-1:0] PAT_JOB    = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd3;

    localparam logic [TICKS_W-1:0] SHORT_TICKS_RST = 16'd100;
    localparam logic [TICKS_W-1:0] LONG_TICKS_RST  = 16'd500;
    localparam logic [TICKS_W-1:0] GAP_TICKS_RST   = 16'd200;
    localparam logic [TICKS_W-1:0] ELAPSED_MAX     = 16'hFFFF;

    localparam logic [STEP_W-1:0] TRIPLE_LAST_STEP = 3'd5;

    typedef struct packed {
        logic active;
        logic buzzer_on;
    } result_t;

endpackage

`default_nettype wire

// File: sv/buzzer_pattern_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer
// Steps one buzzer output level through timed beep patterns.
// ----------------------------------------------------------------------------
// Each input transaction is a one-millisecond tick, a play request with a
// pattern, or a stop, and yields exactly one result transaction with the
// buzzer level and an active flag taken after the update. The block takes
// one transaction per clock while tready is high; its result is registered.
// The update is a single pass of compares against the configured durations,
// so the state registers close in the same cycle the transaction is accepted.
// A two-entry output buffer keeps input flowing while a result waits; tready
// drops only when both entries are full. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module buzzer_pattern_sequencer_unit
    import bps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICKS_W-1:0]   cfg_data,
    // Input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [ACTION_W-1:0]  s_axis_tuser,  // [1:0] action
    input  wire logic [7:0]           s_axis_tdata,  // [2:0] pattern
    // Result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata   // [0] buzzer_on, [1] active
);

    // Configuration registers
    logic               enable_reg;
    logic [TICKS_W-1:0] short_reg;
    logic [TICKS_W-1:0] long_reg;
    logic [TICKS_W-1:0] gap_reg;

    // Sequencer state
    logic [PATTERN_W-1:0] held_reg,    held_next;
    logic [STEP_W-1:0]    step_reg,    step_next;
    logic [TICKS_W-1:0]   elapsed_reg, elapsed_next;
    logic                 level_reg,   level_next;

    // Output buffer
    result_t head_reg;
    result_t skid_reg;
    logic    head_valid_reg;
    logic    skid_valid_reg;
    result_t result;

    logic                 accept;
    logic                 pop;
    logic [ACTION_W-1:0]  in_action;
    logic [PATTERN_W-1:0] in_pattern;
    logic [TICKS_W-1:0]   elapsed_inc;
    logic [STEP_W-1:0]    step_inc;

    assign in_action  = s_axis_tuser;
    assign in_pattern = s_axis_tdata[2:0];

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = head_valid_reg && m_axis_tready;

    assign m_axis_tvalid = head_valid_reg;
    assign m_axis_tdata  = {6'd0, head_reg.active, head_reg.buzzer_on};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            short_reg  <= SHORT_TICKS_RST;
            long_reg   <= LONG_TICKS_RST;
            gap_reg    <= GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_SHORT:  short_reg  <= cfg_data;
                CFG_LONG:   long_reg   <= cfg_data;
                CFG_GAP:    gap_reg    <= cfg_data;
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        held_next    = held_reg;
        step_next    = step_reg;
        elapsed_next = elapsed_reg;
        level_next   = level_reg;
        elapsed_inc  = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
        step_inc     = step_reg + 3'd1;

        case (in_action)
            ACT_TICK:
            begin
                if (enable_reg && held_reg != PAT_OFF)
                begin
                    elapsed_next = elapsed_inc;
                    case (held_reg)
                        PAT_SHORT:
                        begin
                            if (elapsed_inc >= short_reg)
                            begin
                                held_next  = PAT_OFF;
                                level_next = 1'b0;
                            end
                        end
                        PAT_LONG:
                        begin
                            if (elapsed_inc >= long_reg)
                            begin
                                held_next  = PAT_OFF;
                                level_next = 1'b0;
                            end
                        end
                        PAT_DOUBLE:
                        begin
                            if (step_reg == 3'd0 && elapsed_inc >= short_reg)
                            begin
                                level_next   = 1'b0;
                                step_next    = step_inc;
                                elapsed_next = '0;
                            end
                            else if (step_reg == 3'd1 && elapsed_inc >= gap_reg)
                            begin
                                level_next   = 1'b1;
                                step_next    = step_inc;
                                elapsed_next = '0;
                            end
                            else if (step_reg == 3'd2 && elapsed_inc >= short_reg)
                            begin
                                held_next  = PAT_OFF;
                                level_next = 1'b0;
                            end
                        end
                        PAT_TRIPLE:
                        begin
                            // Even steps sound, odd steps are the gaps.
                            if (!step_reg[0])
                            begin
                                if (elapsed_inc >= short_reg)
                                begin
                                    level_next   = 1'b0;
                                    step_next    = step_inc;
                                    elapsed_next = '0;
                                    if (step_inc >= TRIPLE_LAST_STEP)
                                        held_next = PAT_OFF;
                                end
                            end
                            else if (elapsed_inc >= gap_reg)
                            begin
                                level_next   = 1'b1;
                                step_next    = step_inc;
                                elapsed_next = '0;
                            end
                        end
                        PAT_JOB:
                        begin
                            if (step_reg == 3'd0 && elapsed_inc >= long_reg)
                            begin
                                level_next   = 1'b0;
                                step_next    = step_inc;
                                elapsed_next = '0;
                            end
                            else if ((step_reg == 3'd1 || step_reg == 3'd3)
                                     && elapsed_inc >= gap_reg)
                            begin
                                level_next   = 1'b1;
                                step_next    = step_inc;
                                elapsed_next = '0;
                            end
                            else if (step_reg == 3'd2 && elapsed_inc >= short_reg)
                            begin
                                level_next   = 1'b0;
                                step_next    = step_inc;
                                elapsed_next = '0;
                            end
                            else if (step_reg == 3'd4 && elapsed_inc >= short_reg)
                            begin
                                held_next  = PAT_OFF;
                                level_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // Continuous alarm and the unused code keep sounding.
                            level_next = level_reg;
                        end
                    endcase
                end
            end
            ACT_PLAY:
            begin
                if (enable_reg)
                begin
                    held_next    = in_pattern;
                    step_next    = '0;
                    elapsed_next = '0;
                    if (in_pattern != PAT_OFF)
                        level_next = 1'b1;
                end
            end
            ACT_STOP:
            begin
                held_next  = PAT_OFF;
                level_next = 1'b0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase

        result.buzzer_on = level_next;
        result.active    = (held_next != PAT_OFF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= PAT_OFF;
            step_reg    <= '0;
            elapsed_reg <= '0;
            level_reg   <= 1'b0;
        end
        else if (accept)
        begin
            held_reg    <= held_next;
            step_reg    <= step_next;
            elapsed_reg <= elapsed_next;
            level_reg   <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= accept;
            end
            else
            begin
                head_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                skid_reg <= result;
            end
            else
            begin
                head_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    // The skid entry is only ever filled behind a held head entry.
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid without head entry");

    a_stop_silences: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_action == ACT_STOP |=> !level_reg && held_reg == PAT_OFF)
        else $error("stop did not silence the buzzer");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(elapsed_reg) && $stable(held_reg) && $stable(level_reg))
        else $error("sequencer state moved without a transaction");

    a_off_is_silent_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_action == ACT_TICK && held_reg == PAT_OFF
        |=> $stable(elapsed_reg) && $stable(step_reg))
        else $error("tick advanced an idle sequencer");

endmodule

`default_nettype wire
